// ===== rtl/core/can_acceptance_filter_dispatch_defines.svh =====
// Assertion macros shared by the acceptance filter RTL.
`ifndef CAN_ACCEPTANCE_FILTER_DISPATCH_DEFINES_SVH
`define CAN_ACCEPTANCE_FILTER_DISPATCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CAFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CAFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cafd_pkg.sv =====
// Types and constants of the CAN acceptance filter and frame dispatch.
`default_nettype none

package cafd_pkg;

  localparam logic        CMD_REGISTER = 1'b0;
  localparam logic        CMD_FRAME    = 1'b1;

  localparam logic [2:0]  STAT_REGISTERED = 3'd0;
  localparam logic [2:0]  STAT_BAD_ID     = 3'd1;
  localparam logic [2:0]  STAT_DUPLICATE  = 3'd2;
  localparam logic [2:0]  STAT_FULL       = 3'd3;
  localparam logic [2:0]  STAT_DELIVERED  = 3'd4;
  localparam logic [2:0]  STAT_DROPPED    = 3'd5;

  localparam logic [28:0] ID29_MASK = 29'h1FFF_FFFF;
  localparam logic [28:0] ID11_MASK = 29'h0000_07FF;
  localparam int          STD_SHIFT = 18;
  localparam logic [3:0]  MAX_LEN   = 4'd8;

  // classified command, front to back
  typedef struct packed {
    logic        cmd;
    logic        fifo;
    logic        ftype;
    logic        bad_id;
    logic [28:0] id;
    logic [28:0] mask;
    logic [3:0]  length;
    logic [63:0] data;
  } item_t;

  // one filter table entry
  typedef struct packed {
    logic [28:0] id;
    logic [28:0] mask;
    logic        ftype;
    logic        fifo;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic full;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cafd_req_if.sv =====
// Request channel: filter registration and received frame transactions.
`default_nettype none

interface cafd_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        fifo;
  logic        id_type;
  logic [28:0] filter_id;
  logic [28:0] filter_mask;
  logic [28:0] raw_id;
  logic [3:0]  dlc;
  logic [63:0] rx_data;

  modport source (
    output valid, cmd, fifo, id_type, filter_id, filter_mask, raw_id, dlc, rx_data,
    input  ready
  );
  modport sink (
    input  valid, cmd, fifo, id_type, filter_id, filter_mask, raw_id, dlc, rx_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/cafd_rsp_if.sv =====
// Response channel: one result transaction per request.
`default_nettype none

interface cafd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  entry_index;
  logic [28:0] frame_id;
  logic        out_frame_type;
  logic [3:0]  length;
  logic [63:0] payload;

  modport source (
    output valid, status, entry_index, frame_id, out_frame_type, length, payload,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, frame_id, out_frame_type, length, payload,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/cafd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cafd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cafd_front.sv =====
// Front end: accepts request transactions and classifies them into queue items.
`default_nettype none

module cafd_front (
  cafd_req_if.sink             req,
  output logic                 item_valid,
  input  wire logic            item_ready,
  output cafd_pkg::item_t      item
);

  logic [28:0] std_id;

  assign std_id     = (req.raw_id >> cafd_pkg::STD_SHIFT) & cafd_pkg::ID11_MASK;
  assign item_valid = req.valid;
  assign req.ready  = item_ready;

  always_comb begin
    item        = '0;
    item.cmd    = req.cmd;
    item.fifo   = req.fifo;
    item.ftype  = req.id_type;
    item.data   = req.rx_data;
    if (req.cmd == cafd_pkg::CMD_REGISTER) begin
      item.id     = req.filter_id;
      item.bad_id = !req.id_type && (req.filter_id > cafd_pkg::ID11_MASK);
      if (req.filter_mask == '0) begin
        item.mask = req.id_type ? cafd_pkg::ID29_MASK : cafd_pkg::ID11_MASK;
      end else begin
        item.mask = req.filter_mask;
      end
    end else begin
      item.id     = req.id_type ? req.raw_id : std_id;
      item.length = (req.dlc > cafd_pkg::MAX_LEN) ? cafd_pkg::MAX_LEN : req.dlc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cafd_queue.sv =====
// Two-entry queue decoupling the front end from the table scan engine.
`default_nettype none

module cafd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cafd_pkg::item_t  in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cafd_pkg::item_t       out_item
);

  cafd_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cafd_back.sv =====
// Back end: scans the filter table one entry per cycle and drives the result register.
`default_nettype none

module cafd_back #(
  parameter int MAX_FILTERS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire cafd_pkg::item_t  item,
  cafd_rsp_if.source            rsp,
  output cafd_pkg::back_stat_t  stat
);

  localparam int AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CW = $clog2(MAX_FILTERS + 1);
  localparam int EW = $bits(cafd_pkg::entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state;
  cafd_pkg::item_t  cur;
  logic [CW-1:0]    ptr;
  logic [CW-1:0]    count;
  logic             pend;
  logic [AW-1:0]    pend_idx;

  logic [2:0]       res_status;
  logic [2:0]       res_index;
  logic [28:0]      res_id;
  logic             res_ftype;
  logic [3:0]       res_length;
  logic [63:0]      res_data;

  logic             out_valid;
  logic [2:0]       out_status;
  logic [2:0]       out_index;
  logic [28:0]      out_id;
  logic             out_ftype;
  logic [3:0]       out_length;
  logic [63:0]      out_data;

  logic             rd_en;
  logic             wr_en;
  logic [EW-1:0]    rdata;
  cafd_pkg::entry_t rd_entry;
  cafd_pkg::entry_t wr_entry;
  logic             hit;
  logic             at_end;
  logic             full;
  logic             out_free;

  assign full     = (count == CW'(MAX_FILTERS));
  assign rd_entry = cafd_pkg::entry_t'(rdata);
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    if (cur.cmd == cafd_pkg::CMD_REGISTER) begin
      hit = pend && (rd_entry.id == cur.id) && (rd_entry.ftype == cur.ftype);
    end else begin
      hit = pend && (rd_entry.fifo == cur.fifo) && (rd_entry.ftype == cur.ftype) &&
            (((cur.id ^ rd_entry.id) & rd_entry.mask) == '0);
    end
  end

  assign at_end     = !hit && (ptr == count);
  assign item_ready = (state == ST_IDLE);
  assign rd_en      = (state == ST_SCAN) && !hit && !at_end;
  assign wr_en      = (state == ST_SCAN) && at_end && !full &&
                      (cur.cmd == cafd_pkg::CMD_REGISTER);

  always_comb begin
    wr_entry       = '0;
    wr_entry.id    = cur.id;
    wr_entry.mask  = cur.mask;
    wr_entry.ftype = cur.ftype;
    wr_entry.fifo  = cur.fifo;
  end

  cafd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_FILTERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur  <= item;
            ptr  <= '0;
            pend <= 1'b0;
            if (item.cmd == cafd_pkg::CMD_REGISTER && item.bad_id) begin
              res_status <= cafd_pkg::STAT_BAD_ID;
              res_index  <= '0;
              res_id     <= '0;
              res_ftype  <= 1'b0;
              res_length <= '0;
              res_data   <= '0;
              state      <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit || at_end) begin
            pend       <= 1'b0;
            state      <= ST_FIN;
            res_index  <= '0;
            res_id     <= '0;
            res_ftype  <= 1'b0;
            res_length <= '0;
            res_data   <= '0;
            if (cur.cmd == cafd_pkg::CMD_REGISTER) begin
              if (hit) begin
                res_status <= cafd_pkg::STAT_DUPLICATE;
              end else if (full) begin
                res_status <= cafd_pkg::STAT_FULL;
              end else begin
                res_status <= cafd_pkg::STAT_REGISTERED;
                res_index  <= 3'(count);
                count      <= count + CW'(1);
              end
            end else if (hit) begin
              res_status <= cafd_pkg::STAT_DELIVERED;
              res_index  <= 3'(pend_idx);
              res_id     <= cur.id;
              res_ftype  <= cur.ftype;
              res_length <= cur.length;
              res_data   <= cur.data;
            end else begin
              res_status <= cafd_pkg::STAT_DROPPED;
            end
          end else begin
            pend     <= 1'b1;
            pend_idx <= ptr[AW-1:0];
            ptr      <= ptr + CW'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_id     <= res_id;
      out_ftype  <= res_ftype;
      out_length <= res_length;
      out_data   <= res_data;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.entry_index    = out_index;
  assign rsp.frame_id       = out_id;
  assign rsp.out_frame_type = out_ftype;
  assign rsp.length         = out_length;
  assign rsp.payload        = out_data;

  assign stat.busy = (state != ST_IDLE);
  assign stat.full = full;

endmodule

`default_nettype wire

// ===== rtl/core/can_acceptance_filter_dispatch.sv =====
// A request passes the two-entry queue; the back end then scans the N registered filters
// (up to MAX_FILTERS) and passes its result to the output register. A bad-id
// registration skips the scan. The scan reads one entry per cycle over the single read
// port; the back end takes no new request until its result has gone to the output
// register, and the two-entry queue keeps accepting meanwhile.
// Reset: rst clears the filter count, queue and result valid flag; table contents undefined.
`default_nettype none

`include "can_acceptance_filter_dispatch_defines.svh"

module can_acceptance_filter_dispatch #(
  parameter int MAX_FILTERS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cafd_req_if.sink   req,
  cafd_rsp_if.source rsp
);

  logic                 fq_valid;
  logic                 fq_ready;
  cafd_pkg::item_t      fq_item;
  logic                 qb_valid;
  logic                 qb_ready;
  cafd_pkg::item_t      qb_item;
  cafd_pkg::back_stat_t stat;
  logic                 rsp_dlv;
  logic                 rsp_other;
  logic                 rsp_blank;
  logic                 rsp_in_range;

  cafd_front u_front (
    .req        (req),
    .item_valid (fq_valid),
    .item_ready (fq_ready),
    .item       (fq_item)
  );

  cafd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  cafd_back #(
    .MAX_FILTERS (MAX_FILTERS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (qb_valid),
    .item_ready (qb_ready),
    .item       (qb_item),
    .rsp        (rsp),
    .stat       (stat)
  );

  assign rsp_dlv      = rsp.valid && (rsp.status == cafd_pkg::STAT_DELIVERED);
  assign rsp_other    = rsp.valid && (rsp.status != cafd_pkg::STAT_DELIVERED);
  assign rsp_blank    = (rsp.frame_id == '0) && (rsp.length == '0) && (rsp.payload == '0) &&
                        !rsp.out_frame_type;
  assign rsp_in_range = (rsp.length <= cafd_pkg::MAX_LEN) &&
                        (rsp.out_frame_type || (rsp.frame_id <= cafd_pkg::ID11_MASK));

  `CAFD_ASSERT_IMP(a_unused_zero, rsp_other, rsp_blank, "non-delivered result carries data")
  `CAFD_ASSERT_IMP(a_deliver_ok, rsp_dlv, rsp_in_range, "delivered frame out of range")
  `CAFD_ASSERT_NXT(a_full_sticky, stat.full, stat.full, "filter table lost entries")
  `CAFD_ASSERT_NXT(a_result_src, !rsp.valid && !stat.busy, !rsp.valid, "result without work")

endmodule

`default_nettype wire
